/* sv/dgskl_pkg.sv */
// ----------------------------------------------------------------------------
// Symmetric divergence unit package
// Field widths, numeric limits, status codes and controller states used by
// the channel interfaces and the divergence unit.
// ----------------------------------------------------------------------------
package dgskl_pkg;

   localparam int MeanWidth     = 24;
   localparam int VarWidth      = 24;
   localparam int DistWidth     = 48;
   localparam int AccWidth      = 56;
   localparam int FracBits      = 16;
   localparam int DiffWidth     = MeanWidth + 1;
   localparam int NumWidth      = 49;
   localparam int DivSteps      = NumWidth;
   localparam int StepCntWidth  = $clog2(DivSteps);

   typedef enum logic [1:0] {
      STATUS_OK        = 2'd0,
      STATUS_ZERO_VAR  = 2'd1,
      STATUS_SATURATED = 2'd2
   } status_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DIFF,
      ST_SQUARE,
      ST_LOAD,
      ST_DIVIDE,
      ST_ACC_A,
      ST_ACC_B,
      ST_FINISH
   } state_type;

endpackage

/* sv/dgskl_if.sv */
// ----------------------------------------------------------------------------
// Symmetric divergence unit channels
// Valid/ready channels for the per-dimension requests and the results.
// ----------------------------------------------------------------------------
interface dgskl_req_if;
   logic                                      valid;
   logic                                      ready;
   logic signed [dgskl_pkg::MeanWidth-1:0]    mean_a;
   logic        [dgskl_pkg::VarWidth-1:0]     variance_a;
   logic signed [dgskl_pkg::MeanWidth-1:0]    mean_b;
   logic        [dgskl_pkg::VarWidth-1:0]     variance_b;
   logic                                      last_dim;

   modport source (output valid, mean_a, variance_a, mean_b, variance_b, last_dim,
                   input ready);
   modport sink   (input valid, mean_a, variance_a, mean_b, variance_b, last_dim,
                   output ready);
endinterface

interface dgskl_rsp_if;
   logic                                 valid;
   logic                                 ready;
   logic [dgskl_pkg::DistWidth-1:0]      distance;
   dgskl_pkg::status_type                status;

   modport source (output valid, distance, status, input ready);
   modport sink   (input valid, distance, status, output ready);
endinterface

/* sv/diagonal_gaussian_sym_kl_unit.sv */
// An accepted request steps through the DIFF, SQUARE, LOAD, DIVIDE, ACC_A, ACC_B and FINISH
// states, or from DIFF straight to FINISH when a variance of the request is zero.
// A new request is taken only in IDLE, once the last one has left FINISH; the two bit-serial
// dividers run in parallel in DIVIDE, one quotient bit per cycle.
// A finished result waits in the output register while the next request is taken.
// Reset is synchronous and active high; it clears the sum, the flags and all control.
// ----------------------------------------------------------------------------
// Diagonal Gaussian symmetric divergence unit
// Accumulates the per-dimension ratio and Mahalanobis terms with two restoring
// dividers and emits half the saturated sum on the request marked as the last dimension.
// ----------------------------------------------------------------------------
module diagonal_gaussian_sym_kl_unit (
   input logic          clock,
   input logic          reset,
   dgskl_req_if.sink    req_ch,
   dgskl_rsp_if.source  rsp_ch
);

   localparam int MW  = dgskl_pkg::MeanWidth;
   localparam int VW  = dgskl_pkg::VarWidth;
   localparam int DW  = dgskl_pkg::DiffWidth;
   localparam int NW  = dgskl_pkg::NumWidth;
   localparam int AW  = dgskl_pkg::AccWidth;
   localparam int OW  = dgskl_pkg::DistWidth;
   localparam int CW  = dgskl_pkg::StepCntWidth;
   localparam int FB  = dgskl_pkg::FracBits;

   dgskl_pkg::state_type state_ff, state_in;

   logic signed [MW-1:0]  mean_a_ff, mean_b_ff;
   logic [VW-1:0]         var_a_ff, var_b_ff;
   logic                  last_ff;
   logic [DW-1:0]         absd_ff;
   logic [NW-1:0]         dsq_ff;
   logic [NW-1:0]         num_a_ff, num_b_ff;
   logic [VW-1:0]         rem_a_ff, rem_b_ff;
   logic [CW-1:0]         count_ff;
   logic [AW-1:0]         sum_acc_ff;
   logic                  zero_seen_ff, ovf_seen_ff;
   logic                  rsp_valid_ff;
   logic [OW-1:0]         rsp_distance_ff;
   dgskl_pkg::status_type rsp_status_ff;

   logic                  accept;
   logic                  zero_var;
   logic                  emit;
   logic signed [DW-1:0]  diff;
   logic [2*DW-1:0]       square;
   logic [VW:0]           trial_a, trial_b;
   logic                  ge_a, ge_b;
   logic [VW-1:0]         rem_a_in, rem_b_in;
   logic [NW-1:0]         add_q;
   logic [AW:0]           acc_sum;

   assign accept   = req_ch.valid && req_ch.ready;
   assign zero_var = (var_a_ff == '0) || (var_b_ff == '0);
   assign emit     = (state_ff == dgskl_pkg::ST_FINISH) && last_ff
                     && (!rsp_valid_ff || rsp_ch.ready);

   assign diff   = $signed({mean_a_ff[MW-1], mean_a_ff}) - $signed({mean_b_ff[MW-1], mean_b_ff});
   assign square = absd_ff * absd_ff;

   // Lane a divides by variance_b, lane b by variance_a.
   assign trial_a  = {rem_a_ff, num_a_ff[NW-1]};
   assign trial_b  = {rem_b_ff, num_b_ff[NW-1]};
   assign ge_a     = trial_a >= {1'b0, var_b_ff};
   assign ge_b     = trial_b >= {1'b0, var_a_ff};
   assign rem_a_in = ge_a ? VW'(trial_a - {1'b0, var_b_ff}) : trial_a[VW-1:0];
   assign rem_b_in = ge_b ? VW'(trial_b - {1'b0, var_a_ff}) : trial_b[VW-1:0];

   assign add_q   = (state_ff == dgskl_pkg::ST_ACC_A) ? num_a_ff : num_b_ff;
   assign acc_sum = {1'b0, sum_acc_ff} + {{(AW + 1 - NW){1'b0}}, add_q};

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= dgskl_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in     = state_ff;
      req_ch.ready = 1'b0;
      unique case (state_ff)
         dgskl_pkg::ST_IDLE: begin
            req_ch.ready = !reset;
            if (req_ch.valid) begin
               state_in = dgskl_pkg::ST_DIFF;
            end
         end
         dgskl_pkg::ST_DIFF: begin
            state_in = zero_var ? dgskl_pkg::ST_FINISH : dgskl_pkg::ST_SQUARE;
         end
         dgskl_pkg::ST_SQUARE: state_in = dgskl_pkg::ST_LOAD;
         dgskl_pkg::ST_LOAD:   state_in = dgskl_pkg::ST_DIVIDE;
         dgskl_pkg::ST_DIVIDE: begin
            if (count_ff == CW'(dgskl_pkg::DivSteps - 1)) begin
               state_in = dgskl_pkg::ST_ACC_A;
            end
         end
         dgskl_pkg::ST_ACC_A:  state_in = dgskl_pkg::ST_ACC_B;
         dgskl_pkg::ST_ACC_B:  state_in = dgskl_pkg::ST_FINISH;
         dgskl_pkg::ST_FINISH: begin
            if (!last_ff || emit) begin
               state_in = dgskl_pkg::ST_IDLE;
            end
         end
         default: state_in = dgskl_pkg::ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         mean_a_ff <= req_ch.mean_a;
         var_a_ff  <= req_ch.variance_a;
         mean_b_ff <= req_ch.mean_b;
         var_b_ff  <= req_ch.variance_b;
         last_ff   <= req_ch.last_dim;
      end
      if (state_ff == dgskl_pkg::ST_DIFF) begin
         absd_ff <= diff[DW-1] ? DW'(-diff) : DW'(diff);
      end
      if (state_ff == dgskl_pkg::ST_SQUARE) begin
         dsq_ff <= square[NW-1:0];
      end
      if (state_ff == dgskl_pkg::ST_LOAD) begin
         num_a_ff <= {{(NW - VW - FB){1'b0}}, var_a_ff, {FB{1'b0}}} + dsq_ff;
         num_b_ff <= {{(NW - VW - FB){1'b0}}, var_b_ff, {FB{1'b0}}} + dsq_ff;
         rem_a_ff <= '0;
         rem_b_ff <= '0;
      end else if (state_ff == dgskl_pkg::ST_DIVIDE) begin
         num_a_ff <= {num_a_ff[NW-2:0], ge_a};
         num_b_ff <= {num_b_ff[NW-2:0], ge_b};
         rem_a_ff <= rem_a_in;
         rem_b_ff <= rem_b_in;
      end
      if (emit) begin
         rsp_distance_ff <= (zero_seen_ff || ovf_seen_ff || (sum_acc_ff[AW-1:OW+1] != '0))
                            ? {OW{1'b1}} : sum_acc_ff[OW:1];
         if (zero_seen_ff) begin
            rsp_status_ff <= dgskl_pkg::STATUS_ZERO_VAR;
         end else if (ovf_seen_ff || (sum_acc_ff[AW-1:OW+1] != '0)) begin
            rsp_status_ff <= dgskl_pkg::STATUS_SATURATED;
         end else begin
            rsp_status_ff <= dgskl_pkg::STATUS_OK;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         sum_acc_ff   <= '0;
         zero_seen_ff <= 1'b0;
         ovf_seen_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (state_ff == dgskl_pkg::ST_DIVIDE) begin
            count_ff <= count_ff + 1'b1;
         end else begin
            count_ff <= '0;
         end
         if (state_ff == dgskl_pkg::ST_DIFF && zero_var) begin
            zero_seen_ff <= 1'b1;
         end
         if (state_ff == dgskl_pkg::ST_ACC_A || state_ff == dgskl_pkg::ST_ACC_B) begin
            if (acc_sum[AW]) begin
               sum_acc_ff  <= {AW{1'b1}};
               ovf_seen_ff <= 1'b1;
            end else begin
               sum_acc_ff <= acc_sum[AW-1:0];
            end
         end
         if (emit) begin
            sum_acc_ff   <= '0;
            zero_seen_ff <= 1'b0;
            ovf_seen_ff  <= 1'b0;
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ch.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   assign rsp_ch.valid    = rsp_valid_ff;
   assign rsp_ch.distance = rsp_distance_ff;
   assign rsp_ch.status   = rsp_status_ff;

endmodule
